### src/jdcal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_pkg
// Shared constants, types and small tables for the day number converter.
// ----------------------------------------------------------------------------
package jdcal_pkg;

  localparam logic [22:0] JdFirst     = 23'd1721424;  // 1 January of year 1
  localparam logic [22:0] JdLast      = 23'd5373484;  // 31 December 9999
  localparam logic [22:0] JdGregorian = 23'd2299161;  // 15 October 1582
  localparam logic [22:0] JdAlphaBase = 23'd1867216;

  localparam logic [63:0] AsciiZero8  = 64'h3030303030303030;
  localparam logic [7:0]  AsciiZero   = 8'h30;

  // Valid bit and out-of-range flag travelling with each beat
  typedef struct packed {
    logic valid;
    logic oor;
  } tag_t;

  // Two ASCII digits of a value below 100
  function automatic logic [15:0] ascii_pair(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    units = v - 7'(7'(tens) * 7'd10);
    return {AsciiZero + 8'(tens), AsciiZero + 8'(units)};
  endfunction

  // floor(30.6001 * e)
  function automatic logic [8:0] month_offset(input logic [4:0] e);
    logic [8:0] r;
    unique case (e)
      5'd0:    r = 9'd0;
      5'd1:    r = 9'd30;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd91;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd183;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd244;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd336;
      5'd12:   r = 9'd367;
      5'd13:   r = 9'd397;
      5'd14:   r = 9'd428;
      5'd15:   r = 9'd459;
      5'd16:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### src/jdcal_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_front
// Range check and Gregorian century correction (alpha), three stages.
// ----------------------------------------------------------------------------
module jdcal_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [22:0]      jd_i,
  output jdcal_pkg::tag_t  tag_o,
  output logic [22:0]      jd_o,
  output logic             greg_o,
  output logic [6:0]       alpha_o
);

  localparam logic [22:0] JdAlphaBaseL = jdcal_pkg::JdAlphaBase;

  jdcal_pkg::tag_t tag1_q, tag2_q, tag3_q;
  logic [22:0] jd1_q, jd2_q, jd3_q;
  logic        greg1_q, greg2_q, greg3_q;
  logic [23:0] xa1_q, xa2_q;
  logic [6:0]  qa2_q, alpha3_q;

  logic [23:0] xa1_d;
  logic [30:0] pa2;
  logic [23:0] ra3;
  logic [6:0]  alpha3_d;

  // 4*(J - base) - 1, only meaningful on the Gregorian side
  assign xa1_d = 24'({jd_i - JdAlphaBaseL, 2'b00} - 25'd1);

  // Reciprocal of 146097 over 2^24; the estimate is low by at most one
  assign pa2 = 31'(xa1_q) * 31'd114;

  always_comb begin
    ra3      = xa2_q - 24'(24'(qa2_q) * 24'd146097);
    alpha3_d = (ra3 >= 24'd146097) ? qa2_q + 7'd1 : qa2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q.valid <= valid_i;
      tag1_q.oor   <= (jd_i < jdcal_pkg::JdFirst) || (jd_i > jdcal_pkg::JdLast);
      tag2_q       <= tag1_q;
      tag3_q       <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    jd1_q    <= jd_i;
    greg1_q  <= (jd_i >= jdcal_pkg::JdGregorian);
    xa1_q    <= xa1_d;
    jd2_q    <= jd1_q;
    greg2_q  <= greg1_q;
    xa2_q    <= xa1_q;
    qa2_q    <= pa2[30:24];
    jd3_q    <= jd2_q;
    greg3_q  <= greg2_q;
    alpha3_q <= alpha3_d;
  end

  assign tag_o   = tag3_q;
  assign jd_o    = jd3_q;
  assign greg_o  = greg3_q;
  assign alpha_o = alpha3_q;

endmodule

### src/jdcal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_core
// Century, day-of-year and month split, seven stages, binary date out.
// ----------------------------------------------------------------------------
module jdcal_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jdcal_pkg::tag_t  tag_i,
  input  logic [22:0]      jd_i,
  input  logic             greg_i,
  input  logic [6:0]       alpha_i,
  output jdcal_pkg::tag_t  tag_o,
  output logic [13:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o
);

  jdcal_pkg::tag_t tag4_q, tag5_q, tag6_q, tag7_q, tag8_q, tag9_q, tag10_q;

  logic [22:0] b4_q, b5_q, b6_q;
  logic [29:0] xc4_q, xc5_q;
  logic [13:0] qc5_q, c6_q, c7_q, c8_q, c9_q;
  logic [8:0]  diff7_q, diff8_q, diff9_q;
  logic [4:0]  qe8_q, e9_q;
  logic [13:0] year10_q;
  logic [3:0]  month10_q;
  logic [4:0]  day10_q;

  logic [22:0] a4, b4;
  logic [29:0] xc4;
  logic [44:0] pc5;
  logic [29:0] rc6;
  logic [13:0] c6_d;
  logic [22:0] d7;
  logic [8:0]  diff7_d;
  logic [28:0] pe8;
  logic [23:0] xe9, re9;
  logic [4:0]  e9_d;
  logic [8:0]  day10;
  logic [4:0]  m10;
  logic [13:0] y10;

  always_comb begin
    a4  = greg_i ? jd_i + 23'd1 + 23'(alpha_i) - 23'(alpha_i[6:2]) : jd_i;
    b4  = a4 + 23'd1524;
    xc4 = 30'(b4) * 30'd100 - 30'd12210;
  end

  // Reciprocal of 36525 over 2^30, corrected in the next stage
  assign pc5 = 45'(xc4_q) * 45'd29397;

  always_comb begin
    rc6  = xc5_q - 30'(30'(qc5_q) * 30'd36525);
    c6_d = (rc6 >= 30'd36525) ? qc5_q + 14'd1 : qc5_q;
  end

  always_comb begin
    d7      = 23'(23'(c6_q) * 23'd365) + 23'(c6_q[13:2]);
    diff7_d = (b6_q >= d7) ? 9'(b6_q - d7) : 9'd0;
  end

  // 10000 * 54 folds the scale and the reciprocal of 306001 over 2^24
  assign pe8 = 29'(diff7_q) * 29'd540000;

  always_comb begin
    xe9  = 24'(diff8_q) * 24'd10000;
    re9  = xe9 - 24'(24'(qe8_q) * 24'd306001);
    e9_d = (re9 >= 24'd306001) ? qe8_q + 5'd1 : qe8_q;
  end

  always_comb begin
    day10 = diff9_q - jdcal_pkg::month_offset(e9_q);
    m10   = (e9_q >= 5'd1) ? e9_q - 5'd1 : 5'd0;
    if (m10 > 5'd12) begin
      m10 = m10 - 5'd12;
    end
    y10 = (c9_q >= 14'd4715) ? c9_q - 14'd4715 : 14'd0;
    if (m10 > 5'd2 && y10 != 14'd0) begin
      y10 = y10 - 14'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag4_q  <= '0;
      tag5_q  <= '0;
      tag6_q  <= '0;
      tag7_q  <= '0;
      tag8_q  <= '0;
      tag9_q  <= '0;
      tag10_q <= '0;
    end else begin
      tag4_q  <= tag_i;
      tag5_q  <= tag4_q;
      tag6_q  <= tag5_q;
      tag7_q  <= tag6_q;
      tag8_q  <= tag7_q;
      tag9_q  <= tag8_q;
      tag10_q <= tag9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b4_q      <= b4;
    xc4_q     <= xc4;
    b5_q      <= b4_q;
    xc5_q     <= xc4_q;
    qc5_q     <= pc5[43:30];
    b6_q      <= b5_q;
    c6_q      <= c6_d;
    c7_q      <= c6_q;
    diff7_q   <= diff7_d;
    c8_q      <= c7_q;
    diff8_q   <= diff7_q;
    qe8_q     <= pe8[28:24];
    c9_q      <= c8_q;
    diff9_q   <= diff8_q;
    e9_q      <= e9_d;
    year10_q  <= y10;
    month10_q <= m10[3:0];
    day10_q   <= day10[4:0];
  end

  assign tag_o   = tag10_q;
  assign year_o  = year10_q;
  assign month_o = month10_q;
  assign day_o   = day10_q;

endmodule

### src/jdcal_fmt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_fmt
// Year split into hundreds and ASCII formatting, three stages.
// ----------------------------------------------------------------------------
module jdcal_fmt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jdcal_pkg::tag_t  tag_i,
  input  logic [13:0]      year_i,
  input  logic [3:0]       month_i,
  input  logic [4:0]       day_i,
  output logic             done_o,
  output logic [13:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_of_month_o,
  output logic [63:0]      ascii_date_o,
  output logic             out_of_range_o
);

  jdcal_pkg::tag_t tag11_q, tag12_q;
  logic            done13_q;

  logic [13:0] year11_q, year12_q, year13_q;
  logic [3:0]  month11_q, month12_q, month13_q;
  logic [4:0]  day11_q, day12_q, day13_q;
  logic [7:0]  yhi11_q;
  logic [6:0]  yhi12_q, ylo12_q;
  logic [63:0] ascii13_q;
  logic        oor13_q;

  logic [21:0] py11;
  logic [13:0] r12;
  logic [6:0]  yhi12_d, ylo12_d;

  // Reciprocal of 100 over 2^14, low by at most one
  assign py11 = 22'(year_i) * 22'd163;

  always_comb begin
    r12 = year11_q - 14'(14'(yhi11_q) * 14'd100);
    if (r12 >= 14'd100) begin
      yhi12_d = 7'(yhi11_q) + 7'd1;
      ylo12_d = 7'(r12 - 14'd100);
    end else begin
      yhi12_d = 7'(yhi11_q);
      ylo12_d = 7'(r12);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag11_q  <= '0;
      tag12_q  <= '0;
      done13_q <= 1'b0;
    end else begin
      tag11_q  <= tag_i;
      tag12_q  <= tag11_q;
      done13_q <= tag12_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    year11_q  <= year_i;
    month11_q <= month_i;
    day11_q   <= day_i;
    yhi11_q   <= py11[21:14];
    year12_q  <= year11_q;
    month12_q <= month11_q;
    day12_q   <= day11_q;
    yhi12_q   <= yhi12_d;
    ylo12_q   <= ylo12_d;
    oor13_q   <= tag12_q.oor;
    // Zero the date for day numbers outside years 1 to 9999
    if (tag12_q.oor) begin
      year13_q  <= '0;
      month13_q <= '0;
      day13_q   <= '0;
      ascii13_q <= jdcal_pkg::AsciiZero8;
    end else begin
      year13_q  <= year12_q;
      month13_q <= month12_q;
      day13_q   <= day12_q;
      ascii13_q <= {jdcal_pkg::ascii_pair(yhi12_q),
                    jdcal_pkg::ascii_pair(ylo12_q),
                    jdcal_pkg::ascii_pair({3'b000, month12_q}),
                    jdcal_pkg::ascii_pair({2'b00, day12_q})};
    end
  end

  assign done_o         = done13_q;
  assign year_o         = year13_q;
  assign month_o        = month13_q;
  assign day_of_month_o = day13_q;
  assign ascii_date_o   = ascii13_q;
  assign out_of_range_o = oor13_q;

endmodule

### src/julian_day_to_calendar_date_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_unit
// Julian day number to calendar date, binary and ASCII yyyymmdd.
// ----------------------------------------------------------------------------
// Usage:
//   Drive julian_day_i and raise start for one cycle per beat. busy is tied
//   low: the unit takes a new day number in every cycle.
//   Each beat gives exactly one result: done_o is high for
//   one cycle with year_o, month_o, day_of_month_o, ascii_date_o and
//   out_of_range_o valid in that cycle. Results leave in input order, one
//   per cycle at full rate.
//   Day numbers from 2299161 onward follow the Gregorian calendar, earlier
//   ones the Julian calendar. Outside years 1 to 9999 out_of_range_o is set,
//   the binary fields read zero and ascii_date_o reads "00000000".
//   Latency and rate are set by the 13-stage pipeline: three stages for the
//   century correction, seven for the month split and three for formatting.
//   Reset clears the valid bits of every stage, so no done_o follows reset
//   until a new beat is taken. The receiver cannot stall the unit; a result
//   not taken in its done_o cycle is gone.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [22:0] julian_day_i,
  output logic        done_o,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [63:0] ascii_date_o,
  output logic        out_of_range_o
);

  jdcal_pkg::tag_t front_tag, core_tag;
  logic [22:0] front_jd;
  logic        front_greg;
  logic [6:0]  front_alpha;
  logic [13:0] core_year;
  logic [3:0]  core_month;
  logic [4:0]  core_day;

  assign busy = 1'b0;

  jdcal_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .jd_i    (julian_day_i),
    .tag_o   (front_tag),
    .jd_o    (front_jd),
    .greg_o  (front_greg),
    .alpha_o (front_alpha)
  );

  jdcal_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (front_tag),
    .jd_i    (front_jd),
    .greg_i  (front_greg),
    .alpha_i (front_alpha),
    .tag_o   (core_tag),
    .year_o  (core_year),
    .month_o (core_month),
    .day_o   (core_day)
  );

  jdcal_fmt u_fmt (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tag_i          (core_tag),
    .year_i         (core_year),
    .month_i        (core_month),
    .day_i          (core_day),
    .done_o         (done_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .ascii_date_o   (ascii_date_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

### sim/julian_day_to_calendar_date_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_unit_tb
// Drives day numbers into the converter with random gaps and checks every
// date that comes out against a predictor of the calendar arithmetic.
// Directed beats cover the range limits, the calendar switch, leap days and bit
// patterns. Random beats follow: most fall inside years 1 to 9999, some near the
// limits or the calendar switch, some anywhere in the 23-bit field.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_unit_tb;

  localparam int PipeLatency = 13;
  localparam int MaxReports  = 10;
  localparam int RandomBeats = 1080;

  typedef struct packed {
    logic [22:0] jd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [63:0] ascii;
    logic        oor;
  } cal_date_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [22:0] julian_day_i;
  logic        done_o;
  logic [13:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [63:0] ascii_date_o;
  logic        out_of_range_o;

  cal_date_t pending_dates[$];
  int        mismatch_count = 0;
  bit        gapless_run    = 1'b0;

  julian_day_to_calendar_date_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .julian_day_i   (julian_day_i),
    .done_o         (done_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .ascii_date_o   (ascii_date_o),
    .out_of_range_o (out_of_range_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Shift decimal digits of value into the low end of acc, most significant first
  function automatic logic [63:0] push_digits(input logic [63:0] acc,
                                              input int unsigned value,
                                              input int count);
    int unsigned scale;
    scale = 1;
    for (int i = 1; i < count; i++) scale = scale * 10;
    for (int i = 0; i < count; i++) begin
      acc   = {acc[55:0], jdcal_pkg::AsciiZero + 8'((value / scale) % 10)};
      scale = scale / 10;
    end
    return acc;
  endfunction

  function automatic cal_date_t calendar_of_day(input logic [22:0] jd);
    cal_date_t       r;
    longint unsigned j, alpha, a, b, c, d, diff, e, dd, mm, yy;
    r.jd = jd;
    j    = jd;
    if (j < jdcal_pkg::JdFirst || j > jdcal_pkg::JdLast) begin
      r.year  = '0;
      r.month = '0;
      r.day   = '0;
      r.ascii = jdcal_pkg::AsciiZero8;
      r.oor   = 1'b1;
      return r;
    end
    if (j >= jdcal_pkg::JdGregorian) begin
      alpha = (4 * (j - jdcal_pkg::JdAlphaBase) - 1) / 146097;
      a     = j + 1 + alpha - alpha / 4;
    end else begin
      a = j;
    end
    b    = a + 1524;
    c    = (100 * b - 12210) / 36525;
    d    = 365 * c + c / 4;
    diff = (b >= d) ? b - d : 0;
    e    = (10000 * diff) / 306001;
    dd   = diff - (306001 * e) / 10000;
    mm   = (e >= 1) ? e - 1 : 0;
    if (mm > 12) mm = mm - 12;
    yy = (c >= 4715) ? c - 4715 : 0;
    if (mm > 2 && yy > 0) yy = yy - 1;
    r.year  = 14'(yy);
    r.month = 4'(mm);
    r.day   = 5'(dd);
    r.ascii = push_digits(push_digits(push_digits(64'd0, int'(yy), 4), int'(mm), 2),
                          int'(dd), 2);
    r.oor   = 1'b0;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [22:0] jd,
                               input logic [63:0] expected, input logic [63:0] actual);
    if (mismatch_count < MaxReports) begin
      $display("%0t: %s mismatch for day %0d: expected %h, got %h",
               $realtime, what, jd, expected, actual);
    end
    mismatch_count++;
  endtask

  // Check the result of this cycle first, then record any beat taken at this edge
  always @(posedge clk_i) begin : track_dates
    cal_date_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_dates.size() == 0) begin
        note_mismatch("unexpected result", '0, 64'd0, {50'd0, year_o});
      end else begin
        want = pending_dates.pop_front();
        if (year_o !== want.year)
          note_mismatch("year", want.jd, 64'(want.year), 64'(year_o));
        if (month_o !== want.month)
          note_mismatch("month", want.jd, 64'(want.month), 64'(month_o));
        if (day_of_month_o !== want.day)
          note_mismatch("day", want.jd, 64'(want.day), 64'(day_of_month_o));
        if (ascii_date_o !== want.ascii)
          note_mismatch("ascii date", want.jd, want.ascii, ascii_date_o);
        if (out_of_range_o !== want.oor)
          note_mismatch("out of range", want.jd, 64'(want.oor), 64'(out_of_range_o));
      end
    end
    if (rst_ni && start && busy === 1'b0) begin
      pending_dates.push_back(calendar_of_day(julian_day_i));
    end
  end

  task automatic send_day(input logic [22:0] jd);
    int gap;
    gap = gapless_run ? 0 : $urandom_range(10, 0);
    repeat (gap) begin
      @(negedge clk_i);
      start        <= 1'b0;
      julian_day_i <= 23'($urandom);
    end
    @(negedge clk_i);
    start        <= 1'b1;
    julian_day_i <= jd;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Hold off until every pending date has come back
  task automatic wait_all_dates;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_range_limits;
    send_day(23'd0);
    send_day(jdcal_pkg::JdFirst - 23'd1);
    send_day(jdcal_pkg::JdFirst);
    send_day(jdcal_pkg::JdFirst + 23'd59);   // 1 March of year 1
    send_day(jdcal_pkg::JdFirst + 23'd364);
    send_day(jdcal_pkg::JdLast - 23'd364);
    send_day(jdcal_pkg::JdLast);
    send_day(jdcal_pkg::JdLast + 23'd1);
    send_day(23'h7FFFFF);
  endtask

  task automatic test_calendar_switch;
    send_day(jdcal_pkg::JdGregorian - 23'd2);
    send_day(jdcal_pkg::JdGregorian - 23'd1);
    send_day(jdcal_pkg::JdGregorian);
    send_day(jdcal_pkg::JdGregorian + 23'd1);
  endtask

  task automatic test_leap_days;
    // around 1 March 1900, not a Gregorian leap year
    send_day(23'd2415079);
    send_day(23'd2415080);
    // around 1 January and 29 February 2000
    send_day(23'd2451544);
    send_day(23'd2451545);
    send_day(23'd2451604);
    send_day(23'd2451605);
    // Julian leap day in 1500
    send_day(23'd2268992);
  endtask

  task automatic test_bit_patterns;
    send_day(23'h2AAAAA);
    send_day(23'h555555);
    send_day(23'h400000);
  endtask

  task automatic test_random_days;
    int          pick;
    logic [22:0] jd;
    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 40 == 0) gapless_run = ($urandom_range(9, 0) < 3);
      pick = $urandom_range(99, 0);
      if (pick < 75) begin
        jd = 23'($urandom_range(int'(jdcal_pkg::JdLast),
                                int'(jdcal_pkg::JdFirst)));
      end else if (pick < 85) begin
        case ($urandom_range(2, 0))
          0:       jd = jdcal_pkg::JdFirst + 23'($urandom_range(80, 0)) - 23'd40;
          1:       jd = jdcal_pkg::JdGregorian + 23'($urandom_range(80, 0)) - 23'd40;
          default: jd = jdcal_pkg::JdLast + 23'($urandom_range(80, 0)) - 23'd40;
        endcase
      end else begin
        jd = 23'($urandom);
      end
      send_day(jd);
      if (n == RandomBeats / 2) wait_all_dates();
    end
    gapless_run = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    julian_day_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_range_limits();
    test_calendar_switch();
    wait_all_dates();
    test_leap_days();
    test_bit_patterns();
    wait_all_dates();
    test_random_days();

    wait_all_dates();
    repeat (PipeLatency + 8) @(posedge clk_i);
    mismatch_count += pending_dates.size();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
